@@ src/rvie_pkg.sv @@
// Shared types and constants for the RV32I integer execute block.
package rvie_pkg;

    localparam int XLEN     = 32;
    localparam int NUM_REGS = 32;
    localparam int REG_W    = 5;

    localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_W-1:0] REG_A0   = 5'd10;
    localparam logic [REG_W-1:0] REG_A7   = 5'd17;

    localparam logic [XLEN-1:0] ECALL_EXIT          = 32'd10;
    localparam logic [XLEN-1:0] ECALL_PRINT         = 32'd1;
    localparam logic [XLEN-1:0] PC_STEP             = 32'd4;
    localparam int              UIMM_SHIFT          = 12;
    localparam logic [XLEN-1:0] START_ADDRESS_RESET = 32'd0;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_AND   = 5'd2,
        OP_OR    = 5'd3,
        OP_XOR   = 5'd4,
        OP_SLT   = 5'd5,
        OP_SLTU  = 5'd6,
        OP_ADDI  = 5'd7,
        OP_ANDI  = 5'd8,
        OP_ORI   = 5'd9,
        OP_SLLI  = 5'd10,
        OP_SRLI  = 5'd11,
        OP_SRAI  = 5'd12,
        OP_LUI   = 5'd13,
        OP_AUIPC = 5'd14,
        OP_BEQ   = 5'd15,
        OP_BNE   = 5'd16,
        OP_BLT   = 5'd17,
        OP_BGE   = 5'd18,
        OP_BLTU  = 5'd19,
        OP_BGEU  = 5'd20,
        OP_JAL   = 5'd21,
        OP_JALR  = 5'd22,
        OP_ECALL = 5'd23
    } t_op;

    typedef struct packed {
        logic [4:0]        operation;
        logic [REG_W-1:0]  dest_reg;
        logic [REG_W-1:0]  src1_reg;
        logic [REG_W-1:0]  src2_reg;
        logic signed [XLEN-1:0] immediate;
    } t_in_item;

    typedef struct packed {
        logic                   write_enable;
        logic [REG_W-1:0]       write_reg;
        logic signed [XLEN-1:0] write_value;
        logic [XLEN-1:0]        next_pc;
        logic                   taken;
        logic                   exit_request;
        logic                   print_request;
        logic signed [XLEN-1:0] print_value;
    } t_out_item;

    // Operands and architectural state handed to the execute logic
    typedef struct packed {
        logic [4:0]       op;
        logic [REG_W-1:0] rd;
        logic [XLEN-1:0]  imm;
        logic [XLEN-1:0]  rs1_val;
        logic [XLEN-1:0]  rs2_val;
        logic [XLEN-1:0]  pc;
        logic [XLEN-1:0]  a0;
        logic [XLEN-1:0]  a7;
    } t_exec_in;

endpackage

@@ src/rvie_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module rvie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old contents on a same-cycle write
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

@@ src/rvie_alu.sv @@
// Execute logic: ALU, shifter, branch compare, jump targets and ecall decode.
module rvie_alu
    import rvie_pkg::*;
(
    input  t_exec_in  i_exec,
    output t_out_item o_result
);

    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] imm_up;
    logic [XLEN-1:0] seq_pc;
    logic [XLEN-1:0] npc;
    logic [XLEN-1:0] val;
    logic [4:0]      sh;
    logic            wr;
    logic            wr_final;
    logic            tk;
    logic            ex;
    logic            pr;
    logic            cond;

    always_comb begin
        a      = i_exec.rs1_val;
        b      = i_exec.rs2_val;
        imm    = i_exec.imm;
        sh     = imm[4:0];
        imm_up = imm << UIMM_SHIFT;
        seq_pc = i_exec.pc + PC_STEP;
        npc    = seq_pc;
        val    = '0;
        wr     = 1'b0;
        tk     = 1'b0;
        ex     = 1'b0;
        pr     = 1'b0;
        cond   = 1'b0;

        unique case (t_op'(i_exec.op))
            OP_ADD:   begin val = a + b;                        wr = 1'b1; end
            OP_SUB:   begin val = a - b;                        wr = 1'b1; end
            OP_AND:   begin val = a & b;                        wr = 1'b1; end
            OP_OR:    begin val = a | b;                        wr = 1'b1; end
            OP_XOR:   begin val = a ^ b;                        wr = 1'b1; end
            OP_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
            OP_SLTU:  begin val = {31'd0, a < b};               wr = 1'b1; end
            OP_ADDI:  begin val = a + imm;                      wr = 1'b1; end
            OP_ANDI:  begin val = a & imm;                      wr = 1'b1; end
            OP_ORI:   begin val = a | imm;                      wr = 1'b1; end
            OP_SLLI:  begin val = a << sh;                      wr = 1'b1; end
            OP_SRLI:  begin val = a >> sh;                      wr = 1'b1; end
            OP_SRAI:  begin val = $unsigned($signed(a) >>> sh); wr = 1'b1; end
            OP_LUI:   begin val = imm_up;                       wr = 1'b1; end
            OP_AUIPC: begin val = i_exec.pc + imm_up;           wr = 1'b1; end
            OP_BEQ:   cond = (a == b);
            OP_BNE:   cond = (a != b);
            OP_BLT:   cond = ($signed(a) < $signed(b));
            OP_BGE:   cond = !($signed(a) < $signed(b));
            OP_BLTU:  cond = (a < b);
            OP_BGEU:  cond = (a >= b);
            OP_JAL: begin
                val = seq_pc;
                wr  = 1'b1;
                npc = i_exec.pc + imm;
                tk  = 1'b1;
            end
            OP_JALR: begin
                val = seq_pc;
                wr  = 1'b1;
                npc = (a + imm) & ~32'd1;
                tk  = 1'b1;
            end
            OP_ECALL: begin
                if (i_exec.a7 == ECALL_EXIT) begin
                    ex = 1'b1;
                end else if (i_exec.a7 == ECALL_PRINT) begin
                    pr = 1'b1;
                end
            end
            default: ;
        endcase

        // conditional branches
        if (cond) begin
            npc = i_exec.pc + imm;
            tk  = 1'b1;
        end

        wr_final = wr && (i_exec.rd != REG_ZERO);

        o_result.write_enable  = wr_final;
        o_result.write_reg     = wr_final ? i_exec.rd : REG_ZERO;
        o_result.write_value   = wr_final ? val : '0;
        o_result.next_pc       = npc;
        o_result.taken         = tk;
        o_result.exit_request  = ex;
        o_result.print_request = pr;
        o_result.print_value   = pr ? i_exec.a0 : '0;
    end

endmodule

@@ src/rv32i_integer_execute.sv @@
// o_out_valid rises after the operand register (operand read) and result register (execute).
// One instruction per cycle unless the output stalls; pc and register write retire in execute.
// A result same-cycle-written is forwarded to the following instruction's operands.
// Reset (synchronous, active low) empties both stages, sets the pc to the start address
// reset value and clears the register file through per-register valid bits (no clearing pass).
// The configuration port accepts a write every cycle.
module rv32i_integer_execute
    import rvie_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_item,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [XLEN-1:0] i_cfg_data
);

    logic in_accept;
    logic out_free;
    logic exec_fire;
    logic exec_we;

    // operand stage
    logic             r_s1_valid;
    logic [4:0]       r_s1_op;
    logic [REG_W-1:0] r_s1_rd;
    logic [XLEN-1:0]  r_s1_imm;
    logic             r_s1_ok1;
    logic             r_s1_ok2;
    logic             r_s1_byp1;
    logic             r_s1_byp2;
    logic [XLEN-1:0]  r_byp_val;
    logic [XLEN-1:0]  ram_rdata1;
    logic [XLEN-1:0]  ram_rdata2;

    // architectural state
    logic [NUM_REGS-1:0] r_valid_bits;
    logic [XLEN-1:0]     r_pc;
    logic [XLEN-1:0]     r_a0;
    logic [XLEN-1:0]     r_a7;
    logic [XLEN-1:0]     r_start_address;

    // result stage
    logic      r_out_valid;
    t_out_item r_out_item;

    t_exec_in  exec_in;
    t_out_item res;

    assign out_free    = !r_out_valid || i_out_ready;
    assign exec_fire   = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || exec_fire;
    assign in_accept   = i_in_valid && o_in_ready;
    assign exec_we     = exec_fire && res.write_enable;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    rvie_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (exec_we),
        .i_waddr   (res.write_reg),
        .i_wdata   (res.write_value),
        .i_re_a    (in_accept),
        .i_raddr_a (i_in_item.src1_reg),
        .o_rdata_a (ram_rdata1),
        .i_re_b    (in_accept),
        .i_raddr_b (i_in_item.src2_reg),
        .o_rdata_b (ram_rdata2)
    );

    always_comb begin
        exec_in.op      = r_s1_op;
        exec_in.rd      = r_s1_rd;
        exec_in.imm     = r_s1_imm;
        exec_in.rs1_val = r_s1_byp1 ? r_byp_val : (r_s1_ok1 ? ram_rdata1 : '0);
        exec_in.rs2_val = r_s1_byp2 ? r_byp_val : (r_s1_ok2 ? ram_rdata2 : '0);
        exec_in.pc      = r_pc;
        exec_in.a0      = r_a0;
        exec_in.a7      = r_a7;
    end

    rvie_alu u_alu (
        .i_exec   (exec_in),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_valid_bits    <= '0;
            r_pc            <= START_ADDRESS_RESET;
            r_a0            <= '0;
            r_a7            <= '0;
            r_start_address <= START_ADDRESS_RESET;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (exec_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= res.next_pc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (exec_we) begin
                r_valid_bits[res.write_reg] <= 1'b1;
                if (res.write_reg == REG_A0) begin
                    r_a0 <= res.write_value;
                end
                if (res.write_reg == REG_A7) begin
                    r_a7 <= res.write_value;
                end
            end

            // reset restores this register too; the pc is reset to START_ADDRESS_RESET, not from it
            if (i_cfg_valid) begin
                r_start_address <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op   <= i_in_item.operation;
            r_s1_rd   <= i_in_item.dest_reg;
            r_s1_imm  <= i_in_item.immediate;
            r_s1_ok1  <= r_valid_bits[i_in_item.src1_reg];
            r_s1_ok2  <= r_valid_bits[i_in_item.src2_reg];
            // the RAM read misses a write retiring on this same edge
            r_s1_byp1 <= exec_we && (res.write_reg == i_in_item.src1_reg);
            r_s1_byp2 <= exec_we && (res.write_reg == i_in_item.src2_reg);
            r_byp_val <= res.write_value;
        end
        if (exec_fire) begin
            r_out_item <= res;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |-> !(res.write_enable && res.write_reg == REG_ZERO))
        else $error("register x0 written");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire && !res.taken |=> r_pc == $past(r_pc) + PC_STEP)
        else $error("sequential pc did not advance by 4");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_we && res.write_reg == REG_A7 |=> r_a7 == $past(res.write_value))
        else $error("a7 shadow out of step with register file");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid && r_valid_bits[0] == 1'b0)
        else $error("result lost or x0 marked valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> !exec_fire || $past(exec_fire) == 1'b0)
        else $error("result register overwritten while stalled");

endmodule
